// ----- design/tbdlp_pkg.sv -----
// Shared types and codes for the three-button debouncer with long press.
package tbdlp_pkg;

  // Event codes given once per poll
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_UP    = 3'd1,
    EV_DOWN  = 3'd2,
    EV_LONG  = 3'd3,
    EV_SHORT = 3'd4
  } event_t;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TIME   = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS_TIME = 1'd1;

  localparam int unsigned CFG_DATA_BITS = 16;

  // Edge report from one debouncer for the current item
  typedef struct packed {
    logic press;    // stable level goes released -> pressed
    logic lift;     // stable level goes pressed -> released
  } edge_t;

endpackage

// ----- design/tbdlp_debounce.sv -----
// Time-based debouncer for one active-low button.
module tbdlp_debounce
  import tbdlp_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     update,
  input  logic                     raw,
  input  logic [TIME_BITS-1:0]     now,
  input  logic [CFG_DATA_BITS-1:0] debounce_time,
  output edge_t                    edges,
  output logic                     level_new
);

  logic                 stable_level;
  logic                 previous_raw;
  logic [TIME_BITS-1:0] change_time;

  logic                 changed;
  logic [TIME_BITS-1:0] change_eff;
  logic [TIME_BITS-1:0] elapsed;
  logic                 take;

  // Restart the timer on a raw change, then accept a level held long enough
  always_comb begin
    changed    = (raw != previous_raw);
    change_eff = changed ? now : change_time;
    elapsed    = now - change_eff;
    take       = (64'(elapsed) > 64'(debounce_time)) && (raw != stable_level);
    edges.press = take && !raw;
    edges.lift  = take && raw;
    level_new   = take ? raw : stable_level;
  end

  // Commit state only when this button is processed in the item
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= 1'b1;
      previous_raw <= 1'b1;
      change_time  <= '0;
    end else if (update) begin
      if (changed) begin
        change_time  <= now;
        previous_raw <= raw;
      end
      stable_level <= level_new;
    end
  end

endmodule

// ----- design/three_button_debounce_long_press.sv -----
// Top level: three debounced buttons with long-press detection on select.
//
// Input channel (in_valid/in_ready) carries one poll per item: raw active-low
// levels of up, down and select plus the free-running millisecond time.
// Output channel (out_valid/out_ready) carries exactly one event_code per
// poll: 0 none, 1 up pressed, 2 down pressed, 3 select long, 4 select short.
// An accepted poll is captured in the input register; from there the debounce
// and event logic feed the result register, which raises out_valid. The
// block takes one poll per cycle while the result register is free or being
// taken; the debouncer state is read and written in the same cycle, so
// consecutive polls need no spacing.
// When the receiver stalls, the result register holds its item and the input
// register takes one more poll; in_ready drops only when both are full.
// Reset (rst, synchronous) empties both registers, sets every stable and raw
// level to released, clears all timestamps and the long-press flag, and loads
// debounce_time = 50 and long_press_time = 1000. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at the next clock edge and are
// meant to happen only while no poll is in flight.
module three_button_debounce_long_press
  import tbdlp_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      up_level,
  input  logic                      down_level,
  input  logic                      select_level,
  input  logic [31:0]               now_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                event_code
);

  // Configuration registers
  logic [CFG_DATA_BITS-1:0] debounce_time;
  logic [CFG_DATA_BITS-1:0] long_press_time;

  // Input register
  logic                 in_full;
  logic                 up_q;
  logic                 down_q;
  logic                 select_q;
  logic [TIME_BITS-1:0] now_q;

  // Select hold tracking
  logic [TIME_BITS-1:0] press_start_time;
  logic                 long_reported;

  // Result register
  event_t event_q;

  logic                 advance;
  logic [63:0]          now_wide;
  logic                 en_up;
  logic                 en_down;
  logic                 en_select;
  edge_t                up_edges;
  edge_t                down_edges;
  edge_t                select_edges;
  logic                 up_stable;
  logic                 down_stable;
  logic                 select_stable;
  logic [TIME_BITS-1:0] press_start_eff;
  logic                 long_reported_eff;
  logic [TIME_BITS-1:0] held;
  logic                 long_fire;
  event_t               event_next;

  assign now_wide = {32'd0, now_ms};

  // Move an item forward when the result register is free or being taken
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Stop early: a press on a higher-priority button skips the rest
  assign en_up     = advance;
  assign en_down   = advance && !up_edges.press;
  assign en_select = en_down && !down_edges.press;

  tbdlp_debounce #(.TIME_BITS(TIME_BITS)) u_up (
    .clk           (clk),
    .rst           (rst),
    .update        (en_up),
    .raw           (up_q),
    .now           (now_q),
    .debounce_time (debounce_time),
    .edges         (up_edges),
    .level_new     (up_stable)
  );

  tbdlp_debounce #(.TIME_BITS(TIME_BITS)) u_down (
    .clk           (clk),
    .rst           (rst),
    .update        (en_down),
    .raw           (down_q),
    .now           (now_q),
    .debounce_time (debounce_time),
    .edges         (down_edges),
    .level_new     (down_stable)
  );

  tbdlp_debounce #(.TIME_BITS(TIME_BITS)) u_select (
    .clk           (clk),
    .rst           (rst),
    .update        (en_select),
    .raw           (select_q),
    .now           (now_q),
    .debounce_time (debounce_time),
    .edges         (select_edges),
    .level_new     (select_stable)
  );

  // Restart the hold timer on a select press, then check the long threshold
  always_comb begin
    press_start_eff   = select_edges.press ? now_q : press_start_time;
    long_reported_eff = select_edges.press ? 1'b0 : long_reported;
    held              = now_q - press_start_eff;
    long_fire         = !select_stable && !long_reported_eff &&
                        (64'(held) >= 64'(long_press_time));
  end

  // Pick the event in priority order
  always_comb begin
    if (up_edges.press) begin
      event_next = EV_UP;
    end else if (down_edges.press) begin
      event_next = EV_DOWN;
    end else if (long_fire) begin
      event_next = EV_LONG;
    end else if (select_edges.lift && !long_reported_eff) begin
      event_next = EV_SHORT;
    end else begin
      event_next = EV_NONE;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= 16'd50;
      long_press_time <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME:   debounce_time   <= cfg_data;
        REG_LONG_PRESS_TIME: long_press_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture an accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      up_q     <= up_level;
      down_q   <= down_level;
      select_q <= select_level;
      now_q    <= now_wide[TIME_BITS-1:0];
    end
  end

  // Update select hold state when select is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      press_start_time <= '0;
      long_reported    <= 1'b0;
    end else if (en_select) begin
      press_start_time <= press_start_eff;
      long_reported    <= long_fire || long_reported_eff;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_q <= event_next;
    end
  end

  assign event_code = event_q;

endmodule
